FILE: hw/rtl/pgbm_pkg.sv
// Shared widths, codes and polynomial constants of the partial gain beating mixer.
`timescale 1ns / 1ps

package pgbm_pkg;

	localparam int IN_TDATA_W  = 56;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 24;

	localparam int IDX_W   = 8;
	localparam int GAIN_W  = 16;
	localparam int LEVEL_W = 16;
	localparam int STRIDE_W = 9;
	localparam int PHASE_W = 24;
	localparam int TICK_W  = 10;
	localparam int SCALED_W = 18;
	localparam int OGAIN_W = 20;
	localparam int POLY_W  = 31;

	typedef enum logic [1:0] {
		OP_PARTIAL  = 2'd0,
		OP_TICK     = 2'd1,
		OP_NOTE_ON  = 2'd2,
		OP_NOTE_OFF = 2'd3
	} op_t;

	localparam logic [CFG_INDEX_W-1:0] REG_OSC1_LEVEL = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OSC2_LEVEL = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STRIDE     = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BEAT_STEP  = 4'd3;

	localparam logic [POLY_W-1:0] COEF_C1 = 31'd1324675879;
	localparam logic [POLY_W-1:0] COEF_C2 = 31'd272375560;
	localparam logic [POLY_W-1:0] COEF_C3 = 31'd22401992;
	localparam logic [POLY_W-1:0] COEF_C4 = 31'd987048;
	localparam logic [POLY_W-1:0] COEF_C5 = 31'd27061;
	localparam logic [POLY_W-1:0] ONE_Q30 = 31'd1073741824;

	localparam logic [2:0] COS_LAST_STEP = 3'd5;

	// Horner coefficient used at each step of the cosine evaluation
	function automatic logic [POLY_W-1:0] cos_coef(input logic [2:0] step);
		logic [POLY_W-1:0] c;
		case (step)
			3'd1: c = COEF_C4;
			3'd2: c = COEF_C3;
			3'd3: c = COEF_C2;
			3'd4: c = COEF_C1;
			default: c = COEF_C5;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/partial_gain_beating_mixer.sv
// Top level of the partial gain beating mixer: control, gain store and cosine unit.
`timescale 1ns / 1ps

// Usage
// s_axis carries one item per transfer: tuser is the op (partial, tick, note on,
// note off), tdata the partial index, both oscillator gains and the tick sample count.
// m_axis returns one result per partial item: the index and the mixed signed Q4.16 gain.
// Ticks and note items give no result. cfg writes one register per transfer
// (0 osc1_level, 1 osc2_level, 2 harmonic_stride, 3 beat_step); write only while idle.
// Items are handled one at a time. A partial item skips the divide when it is inactive,
// osc2_level is zero, the stride is zero or the index is out of range; otherwise a
// bit-serial divide finds k, and the item mixes only if the division is exact: the
// store is read at k-1 and a 6-step Horner evaluation on one shared 31x31 multiplier
// gives the cosine. With m_axis ready, the next item is taken at the same edge as the
// result transfer.
// The output register holds a finished result while m_axis stalls; the next item is
// taken meanwhile and a new result waits in its last state until the register frees.
// Reset clears the phase, the active flag and the registers to their defaults; the
// gain store is not cleared and needs no clearing pass only if each mix reads a partial
// already written; the user must ensure this, as the block itself does not enforce it.
module partial_gain_beating_mixer #(
	parameter int NUM_PARTIALS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [7:0] partial_index, [23:8] osc1_partial, [39:24] osc2_partial,
	// [49:40] tick_samples, [55:50] zero
	input  logic [pgbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// [1:0] op
	input  logic [pgbm_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [7:0] out_index, [27:8] out_gain, [31:28] zero
	output logic [pgbm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pgbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pgbm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pgbm_pkg::*;

	localparam int AW = (NUM_PARTIALS > 1) ? $clog2(NUM_PARTIALS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_STORE, ST_DIV, ST_ANG, ST_COS, ST_MUL, ST_FIN
	} state_t;

	state_t state_q;

	logic [LEVEL_W-1:0]  osc1_level_q, osc2_level_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [PHASE_W-1:0]  beat_step_q;
	logic [PHASE_W-1:0]  phase_q;
	logic                active_q;

	op_t                 op_q;
	logic [IDX_W-1:0]    idx_q;
	logic [GAIN_W-1:0]   g1_q, g2_q;
	logic [TICK_W-1:0]   ts_q;

	logic [SCALED_W-1:0] a_q, b_q;
	logic                act_q, mixok_q, inrange_q, use_mix_q;

	logic [STRIDE_W-1:0] dvd_q, rem_q, quo_q;
	logic [3:0]          cnt_q;

	logic [PHASE_W-1:0]  ang_q;
	logic [2:0]          step_q;
	logic [POLY_W-1:0]   z_q, t_q;
	logic                neg_q;
	logic signed [15:0]  c_q;
	logic signed [34:0]  prod_q;

	logic [SCALED_W-1:0] store_mem [NUM_PARTIALS];
	logic [SCALED_W-1:0] rd_q;

	logic [IDX_W-1:0]    out_idx_q;
	logic [OGAIN_W-1:0]  out_gain_q;
	logic                out_valid_q;

	// datapath
	logic [32:0]         a_full, b_full;
	logic [33:0]         tick_inc;
	logic [32:0]         ang_full;
	logic [STRIDE_W:0]   div_trial;
	logic                div_ge;
	logic [15:0]         xe;
	logic [31:0]         x_sq;
	logic [61:0]         poly_mul;
	logic [31:0]         poly_p;
	logic [POLY_W-1:0]   poly_v;
	logic [16:0]         poly_r;
	logic [15:0]         cos_mag;
	logic signed [34:0]  prod_rnd;
	logic [OGAIN_W-1:0]  gain_base, gain_term, gain_sum;
	logic                out_free;
	logic                in_range;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_gain_q, out_idx_q};

	assign a_full   = 33'(g1_q) * 33'(osc1_level_q) + 33'd8192;
	assign b_full   = 33'(g2_q) * 33'(osc2_level_q) + 33'd8192;
	assign tick_inc = beat_step_q * ts_q;
	assign ang_full = quo_q * phase_q;
	assign in_range = (32'(idx_q) < 32'(NUM_PARTIALS));

	assign div_trial = {rem_q, dvd_q[STRIDE_W-1]};
	assign div_ge    = (div_trial >= {1'b0, stride_q});

	assign xe       = ang_q[22] ? (16'd32768 - {1'b0, ang_q[21:7]}) : {1'b0, ang_q[21:7]};
	assign x_sq     = xe * xe;
	assign poly_mul = z_q * t_q;
	assign poly_p   = poly_mul[61:30];
	assign poly_v   = (poly_p >= {1'b0, ONE_Q30}) ? '0 : (ONE_Q30 - poly_p[POLY_W-1:0]);
	assign poly_r   = 17'((32'(poly_v) + 32'd16384) >> 15);
	assign cos_mag  = (poly_r > 17'd32767) ? 16'd32767 : poly_r[15:0];

	assign prod_rnd  = prod_q + 35'sd16384;
	assign gain_term = use_mix_q ? prod_rnd[34:15] : '0;
	assign gain_base = act_q ? {2'd0, a_q} : '0;
	assign gain_sum  = gain_base + gain_term;
	assign out_free  = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc1_level_q <= 16'd16384;
			osc2_level_q <= '0;
			stride_q     <= 9'd1;
			beat_step_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OSC1_LEVEL: osc1_level_q <= cfg_data[LEVEL_W-1:0];
				REG_OSC2_LEVEL: osc2_level_q <= cfg_data[LEVEL_W-1:0];
				REG_STRIDE:     stride_q     <= cfg_data[STRIDE_W-1:0];
				REG_BEAT_STEP:  beat_step_q  <= cfg_data[PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_STORE && inrange_q) begin
			store_mem[AW'(idx_q)] <= b_q;
		end
		if (state_q == ST_ANG) begin
			rd_q <= store_mem[AW'(quo_q - 9'd1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= op_t'(s_axis_tuser[1:0]);
						idx_q   <= s_axis_tdata[7:0];
						g1_q    <= s_axis_tdata[23:8];
						g2_q    <= s_axis_tdata[39:24];
						ts_q    <= s_axis_tdata[49:40];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (op_q)
						OP_TICK: begin
							phase_q <= phase_q + tick_inc[PHASE_W-1:0];
							state_q <= ST_IDLE;
						end
						OP_NOTE_ON: begin
							active_q <= 1'b1;
							if (beat_step_q == '0) begin
								phase_q <= '0;
							end
							state_q <= ST_IDLE;
						end
						OP_NOTE_OFF: begin
							active_q <= 1'b0;
							state_q  <= ST_IDLE;
						end
						default: begin
							a_q       <= a_full[31:14];
							b_q       <= b_full[31:14];
							act_q     <= active_q;
							inrange_q <= in_range;
							mixok_q   <= active_q && in_range && (osc2_level_q != '0)
							             && (stride_q != '0);
							use_mix_q <= 1'b0;
							dvd_q     <= 9'(idx_q) + 9'd1;
							rem_q     <= '0;
							cnt_q     <= 4'(STRIDE_W - 1);
							state_q   <= ST_STORE;
						end
					endcase
				end
				ST_STORE: begin
					state_q <= mixok_q ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					rem_q <= div_ge ? (div_trial[STRIDE_W-1:0] - stride_q)
					                : div_trial[STRIDE_W-1:0];
					quo_q <= {quo_q[STRIDE_W-2:0], div_ge};
					dvd_q <= {dvd_q[STRIDE_W-2:0], 1'b0};
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == '0) begin
						if ((div_ge ? (div_trial[STRIDE_W-1:0] - stride_q)
						            : div_trial[STRIDE_W-1:0]) == '0) begin
							state_q <= ST_ANG;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_ANG: begin
					ang_q   <= ang_full[PHASE_W-1:0];
					step_q  <= '0;
					state_q <= ST_COS;
				end
				ST_COS: begin
					step_q <= step_q + 3'd1;
					if (step_q == '0) begin
						z_q   <= x_sq[POLY_W-1:0];
						t_q   <= cos_coef(step_q);
						neg_q <= ang_q[23] ^ ang_q[22];
					end else if (step_q == COS_LAST_STEP) begin
						c_q     <= neg_q ? -$signed(cos_mag) : $signed(cos_mag);
						state_q <= ST_MUL;
					end else begin
						t_q <= cos_coef(step_q) - poly_p[POLY_W-1:0];
					end
				end
				ST_MUL: begin
					prod_q    <= $signed({17'd0, rd_q}) * 35'(c_q);
					use_mix_q <= 1'b1;
					state_q   <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_idx_q  <= idx_q;
						out_gain_q <= gain_sum;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cos_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COS |-> step_q <= COS_LAST_STEP)
		else $error("cosine step count overran");

	a_mix_k: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ANG |-> quo_q != '0 && rem_q == '0 && stride_q != '0)
		else $error("mix entered without an exact nonzero multiple");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the final state");

	a_mix_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> act_q && inrange_q)
		else $error("mix on an inactive or out-of-range partial");

endmodule

FILE: sim/pgbm_checker.sv
// Checker for the partial gain beating mixer: watches all channels, predicts and compares results.
`timescale 1ns / 1ps

module pgbm_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	input  logic [pgbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  logic [pgbm_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic [pgbm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [pgbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pgbm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                  errors,
	output int                                  pending,
	output int                                  checked
);

	import pgbm_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0]   index;
		logic [OGAIN_W-1:0] gain;
	} gain_result_t;

	gain_result_t        gain_q[$];
	logic [SCALED_W-1:0] osc2_mem [256];
	logic [PHASE_W-1:0]  phase;
	logic                note_active;
	logic [LEVEL_W-1:0]  osc1_lvl;
	logic [LEVEL_W-1:0]  osc2_lvl;
	logic [STRIDE_W-1:0] stride;
	logic [PHASE_W-1:0]  beat_step;
	int                  err_cnt;
	int                  chk_cnt;

	// cos(pi/2 * x) for x in [0, 32768], Q1.15
	function automatic int cos_quarter(input logic [15:0] x);
		logic [63:0] z;
		logic [63:0] t;
		logic [63:0] p;
		logic [63:0] v;
		z = 64'(x) * 64'(x);
		t = 64'(COEF_C5);
		t = 64'(COEF_C4) - ((z * t) >> 30);
		t = 64'(COEF_C3) - ((z * t) >> 30);
		t = 64'(COEF_C2) - ((z * t) >> 30);
		t = 64'(COEF_C1) - ((z * t) >> 30);
		p = (z * t) >> 30;
		v = (p >= 64'(ONE_Q30)) ? 64'd0 : 64'(ONE_Q30) - p;
		v = (v + 64'd16384) >> 15;
		if (v > 64'd32767)
			v = 64'd32767;
		return int'(v);
	endfunction

	function automatic int beat_cos(input logic [PHASE_W-1:0] ang);
		logic [15:0] x;
		int          c;
		x = {1'b0, ang[21:7]};
		case (ang[23:22])
			2'd0: c = cos_quarter(x);
			2'd1: c = -cos_quarter(16'd32768 - x);
			2'd2: c = -cos_quarter(x);
			default: c = cos_quarter(16'd32768 - x);
		endcase
		return c;
	endfunction

	// store the scaled osc2 gain and return the mixed gain of one partial
	function automatic logic [OGAIN_W-1:0] mix_partial(input logic [IDX_W-1:0] idx,
			input logic [GAIN_W-1:0] g1, input logic [GAIN_W-1:0] g2);
		logic [63:0]        a;
		logic [63:0]        b;
		logic [63:0]        ang;
		longint             gain;
		longint             prod;
		int                 k;
		a = (64'(g1) * 64'(osc1_lvl) + 64'd8192) >> 14;
		b = (64'(g2) * 64'(osc2_lvl) + 64'd8192) >> 14;
		osc2_mem[idx] = b[SCALED_W-1:0];
		gain = 0;
		if (note_active) begin
			gain = longint'(a);
			if (osc2_lvl != 0 && stride != 0 && ((int'(idx) + 1) % int'(stride)) == 0) begin
				k = (int'(idx) + 1) / int'(stride);
				ang = 64'(k) * 64'(phase);
				prod = longint'(osc2_mem[k - 1]) * longint'(beat_cos(ang[PHASE_W-1:0]));
				gain = gain + ((prod + 16384) >>> 15);
			end
		end
		return gain[OGAIN_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		gain_result_t want;
		gain_result_t got;
		op_t          op;
		logic [IDX_W-1:0]  idx;
		logic [GAIN_W-1:0] g1;
		logic [GAIN_W-1:0] g2;
		logic [TICK_W-1:0] ts;
		if (!arst_n) begin
			gain_q.delete();
			phase       = '0;
			note_active = 1'b0;
			osc1_lvl    = 16'd16384;
			osc2_lvl    = '0;
			stride      = 9'd1;
			beat_step   = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_OSC1_LEVEL: osc1_lvl = cfg_data[LEVEL_W-1:0];
					REG_OSC2_LEVEL: osc2_lvl = cfg_data[LEVEL_W-1:0];
					REG_STRIDE:     stride = cfg_data[STRIDE_W-1:0];
					REG_BEAT_STEP:  beat_step = cfg_data[PHASE_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.index = m_axis_tdata[7:0];
				got.gain  = m_axis_tdata[27:8];
				if (gain_q.size() == 0) begin
					$error("unexpected result transfer: index %0d gain %0d",
						got.index, $signed(got.gain));
					err_cnt++;
				end else begin
					want = gain_q.pop_front();
					chk_cnt++;
					if (got.index !== want.index) begin
						$error("out_index: expected %0d, got %0d", want.index, got.index);
						err_cnt++;
					end
					if (got.gain !== want.gain) begin
						$error("out_gain: expected %0d, got %0d",
							$signed(want.gain), $signed(got.gain));
						err_cnt++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				op  = op_t'(s_axis_tuser);
				idx = s_axis_tdata[7:0];
				g1  = s_axis_tdata[23:8];
				g2  = s_axis_tdata[39:24];
				ts  = s_axis_tdata[49:40];
				case (op)
					OP_TICK: phase = PHASE_W'(64'(phase) + 64'(beat_step) * 64'(ts));
					OP_NOTE_ON: begin
						note_active = 1'b1;
						if (beat_step == 0)
							phase = '0;
					end
					OP_NOTE_OFF: note_active = 1'b0;
					default: begin
						want.index = idx;
						want.gain  = mix_partial(idx, g1, g2);
						gain_q.push_back(want);
					end
				endcase
			end
		end
		errors  <= err_cnt;
		pending <= gain_q.size();
		checked <= chk_cnt;
	end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the partial gain beating mixer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

	import pgbm_pkg::*;

	localparam int NUM_SETTINGS      = 12;
	localparam int ITEMS_PER_SETTING = 143;
	localparam int SETTLE_CYCLES     = 40;
	localparam int HOLD_CYCLES       = 400;
	localparam int HOLD_AFTER        = 300;
	localparam int LIMIT_CYCLES      = 400000;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 4'd15;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 4'd4;

	typedef struct packed {
		logic [LEVEL_W-1:0]  osc1;
		logic [LEVEL_W-1:0]  osc2;
		logic [STRIDE_W-1:0] stride;
		logic [PHASE_W-1:0]  step;
	} mix_setting_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int errors;
	int pending;
	int checked;

	mix_setting_t        settings [NUM_SETTINGS];
	logic [STRIDE_W-1:0] cur_stride = 9'd1;
	bit                  written [256];
	bit                  note_on_now = 1'b0;
	int                  items_sent = 0;
	int                  burst_left = 0;
	int                  cycle_count = 0;
	int                  hold_left = 0;
	bit                  hold_done = 1'b0;
	logic [9:0]          rx_cycle = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	partial_gain_beating_mixer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	pgbm_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending),
		.checked       (checked)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: hold off once for a long stretch, otherwise rotate stall patterns
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1'b1;
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && checked >= HOLD_AFTER) begin
			m_axis_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			case (rx_cycle[9:8])
				2'd0: m_axis_tready <= 1'b1;
				2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2'd2: m_axis_tready <= ($urandom_range(0, 1) != 0);
				default: m_axis_tready <= (rx_cycle[2:0] == 3'd0);
			endcase
		end
	end

	function automatic logic [GAIN_W-1:0] rand_gain();
		logic [GAIN_W-1:0] g;
		case ($urandom_range(0, 9))
			0: g = '0;
			1: g = '1;
			default: g = GAIN_W'($urandom);
		endcase
		return g;
	endfunction

	// a mixed partial must read a store entry that was already written
	function automatic bit mix_safe(input int idx);
		int k;
		if (cur_stride == 0 || ((idx + 1) % int'(cur_stride)) != 0)
			return 1'b1;
		k = (idx + 1) / int'(cur_stride);
		return (k - 1 == idx) || written[k - 1];
	endfunction

	task automatic send_item(input op_t op, input logic [IDX_W-1:0] idx,
			input logic [GAIN_W-1:0] g1, input logic [GAIN_W-1:0] g2,
			input logic [TICK_W-1:0] ts);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, ts, g2, g1, idx};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
		case (op)
			OP_PARTIAL:  written[idx] = 1'b1;
			OP_NOTE_ON:  note_on_now = 1'b1;
			OP_NOTE_OFF: note_on_now = 1'b0;
			default: ;
		endcase
	endtask

	task automatic send_partial(input int idx, input logic [GAIN_W-1:0] g1,
			input logic [GAIN_W-1:0] g2);
		if (mix_safe(idx))
			send_item(OP_PARTIAL, IDX_W'(idx), g1, g2, TICK_W'($urandom));
	endtask

	task automatic send_ctrl(input op_t op, input logic [TICK_W-1:0] ts);
		send_item(op, IDX_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom), ts);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// drop valid, wait for every result, then let the last control item finish
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input mix_setting_t s);
		drain();
		write_reg(REG_OSC1_LEVEL, CFG_DATA_W'(s.osc1));
		write_reg(REG_OSC2_LEVEL, CFG_DATA_W'(s.osc2));
		write_reg(REG_STRIDE, CFG_DATA_W'(s.stride));
		write_reg(REG_BEAT_STEP, s.step);
		cfg_valid <= 1'b0;
		cur_stride = s.stride;
	endtask

	// one frame: optional note on, a tick, ascending partials, then an optional note off
	task automatic run_frame();
		int idx;
		int len;
		int keep;
		int n;
		if (!note_on_now || $urandom_range(0, 3) == 0)
			send_ctrl(OP_NOTE_ON, TICK_W'($urandom));
		send_ctrl(OP_TICK, TICK_W'($urandom));
		idx = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
		keep = $urandom_range(40, 100);
		len = $urandom_range(4, 40);
		n = 0;
		while (idx < 256 && n < len) begin
			if ($urandom_range(1, 100) <= keep) begin
				send_partial(idx, rand_gain(), rand_gain());
				n++;
			end
			idx++;
		end
		if ($urandom_range(0, 5) == 0)
			send_ctrl(OP_NOTE_OFF, TICK_W'($urandom));
	endtask

	task automatic run_random(input int count);
		int start;
		op_t op;
		start = items_sent;
		while (items_sent - start < count) begin
			if ($urandom_range(0, 99) < 80) begin
				run_frame();
			end else begin
				op = op_t'($urandom_range(0, 3));
				if (op == OP_PARTIAL)
					send_partial($urandom_range(0, 255), rand_gain(), rand_gain());
				else
					send_ctrl(op, TICK_W'($urandom));
			end
		end
	endtask

	initial begin
		settings[0]  = {16'd65535, 16'd65535, 9'd1, 24'hFFFFFF};
		settings[1]  = {16'd16384, 16'd30000, 9'd2, 24'h000000};
		settings[2]  = {16'd16384, 16'd16384, 9'd1, 24'h000100};
		settings[3]  = {16'd65535, 16'd65535, 9'd256, 24'hFFFFFF};
		settings[4]  = {16'd0, 16'd40000, 9'd3, 24'h123456};
		settings[5]  = {16'd12345, 16'd0, 9'd2, 24'd777};
		settings[6]  = {16'd30000, 16'd50000, 9'd0, 24'd5000};
		settings[7]  = {16'd20000, 16'd20000, 9'd300, 24'd1};
		settings[8]  = {16'd65535, 16'd65535, 9'd511, 24'd0};
		settings[9]  = {16'($urandom), 16'($urandom_range(1, 65535)),
			9'($urandom_range(1, 16)), 24'($urandom)};
		settings[10] = {16'd8000, 16'd65535, 9'd7, 24'h800000};
		settings[11] = {16'd16384, 16'd16384, 9'd1, 24'($urandom)};

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: inactive output, note switching, no mixing
		send_partial(0, 16'hFFFF, 16'hFFFF);
		send_ctrl(OP_NOTE_OFF, 10'd0);
		send_ctrl(OP_TICK, 10'd1023);
		send_ctrl(OP_NOTE_ON, 10'd0);
		send_partial(0, 16'hFFFF, 16'h0000);
		send_partial(1, 16'h0000, 16'hFFFF);
		send_partial(255, 16'hFFFF, 16'hFFFF);

		// full levels, maximum step, plus writes to unused register indexes
		apply_setting(settings[0]);
		@(posedge clk);
		write_reg(REG_SPARE_HI, 24'hFFFFFF);
		write_reg(REG_SPARE_LO, 24'h000000);
		cfg_valid <= 1'b0;
		send_ctrl(OP_NOTE_ON, 10'd0);
		send_ctrl(OP_TICK, 10'd1023);
		send_partial(0, 16'hFFFF, 16'hFFFF);
		send_partial(1, 16'h0000, 16'hFFFF);
		send_partial(2, 16'hFFFF, 16'h0000);
		send_partial(3, 16'h8000, 16'h8000);
		send_ctrl(OP_TICK, 10'd1);
		send_partial(127, 16'hAAAA, 16'h5555);
		send_partial(254, 16'hFFFF, 16'hFFFF);
		send_partial(255, 16'hFFFF, 16'hFFFF);
		send_ctrl(OP_NOTE_OFF, 10'd0);
		send_partial(100, 16'hFFFF, 16'hFFFF);
		send_ctrl(OP_NOTE_ON, 10'd0);
		send_ctrl(OP_TICK, 10'd0);
		send_partial(200, 16'h1234, 16'hFFFF);

		// zero step: note on clears the phase
		apply_setting(settings[1]);
		send_ctrl(OP_NOTE_ON, 10'd0);
		send_partial(1, 16'hFFFF, 16'hFFFF);
		send_partial(3, 16'hFFFF, 16'hFFFF);

		for (int n = 2; n < NUM_SETTINGS; n++) begin
			apply_setting(settings[n]);
			run_random(ITEMS_PER_SETTING);
		end

		drain();
		$display("Run covered %0d input items over %0d register settings, %0d results checked,",
			items_sent, NUM_SETTINGS, checked);
		$display("with strides of zero and above 256, ticks, note switching, a long stall.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
